// ===== rtl/core/bounded_deque_with_search_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque with search
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_MACROS_SVH

// check that cons holds in the same cycle as ante
`define BDQS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that cons holds in the cycle after ante
`define BDQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bdqs_pkg.sv =====
// ----------------------------------------------------------------------------
// bdqs_pkg
// Field widths, command and status codes, and cell control types.
// ----------------------------------------------------------------------------
package bdqs_pkg;

    localparam int CMD_W    = 3;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_SHR       = 2'd1,
        CELL_SHL       = 2'd2,
        CELL_PUSH_BACK = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [VAL_W-1:0] operand;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/bdqs_if.sv =====
// ----------------------------------------------------------------------------
// bdqs_cmd_if / bdqs_res_if
// Valid/ready channels for command requests and result requests.
// ----------------------------------------------------------------------------
interface bdqs_cmd_if;
    import bdqs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [VAL_W-1:0] operand_value;

    modport source (output valid, output command, output operand_value, input ready);
    modport sink   (input valid, input command, input operand_value, output ready);
endinterface

interface bdqs_res_if;
    import bdqs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] result_value;
    logic [POS_W-1:0]        position;
    logic                    last;

    modport source (output valid, output status, output result_value, output position,
                    output last, input ready);
    modport sink   (input valid, input status, input result_value, input position,
                    input last, output ready);
endinterface

// ===== rtl/core/bdqs_cell.sv =====
// ----------------------------------------------------------------------------
// bdqs_cell
// One list entry: shifts toward either neighbor or loads a pushed value.
// ----------------------------------------------------------------------------
module bdqs_cell #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic                             clk,
    input  bdqs_pkg::cell_ctrl_t             ctl,
    input  logic [CNT_W-1:0]                 fill_count,
    input  logic signed [bdqs_pkg::VAL_W-1:0] left_value,
    input  logic signed [bdqs_pkg::VAL_W-1:0] right_value,
    output logic signed [bdqs_pkg::VAL_W-1:0] value
);
    import bdqs_pkg::*;

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctl.op)
            CELL_HOLD:      value_next = value_reg;
            CELL_SHR:       value_next = left_value;
            CELL_SHL:       value_next = right_value;
            CELL_PUSH_BACK:
            begin
                if (fill_count == CNT_W'(INDEX))
                begin
                    value_next = ctl.operand;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== rtl/core/bdqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdqs_ctrl
// Command sequencer: entry count, walk over the cell row, result register.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_top_macros.svh"

module bdqs_ctrl #(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bdqs_cmd_if.sink                          cmd,
    bdqs_res_if.source                        res,
    input  logic signed [bdqs_pkg::VAL_W-1:0] head,
    output bdqs_pkg::cell_ctrl_t              ctl,
    output logic [CNT_W-1:0]                  fill_count
);
    import bdqs_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t                  state_reg,  state_next;
    logic [CNT_W-1:0]        count_reg,  count_next;
    logic [IDX_W-1:0]        step_reg,   step_next;
    logic [CMD_W-1:0]        wcmd_reg,   wcmd_next;
    logic signed [VAL_W-1:0] key_reg,    key_next;
    logic                    found_reg,  found_next;
    logic                    rvalid_reg, rvalid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic signed [VAL_W-1:0] rval_reg,   rval_next;
    logic [POS_W-1:0]        pos_reg,    pos_next;
    logic                    last_reg,   last_next;

    logic             out_free;
    logic             in_fire;
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] step_cnt;
    logic [IDX_W:0]   step_inc;
    logic [POS_W-1:0] step_pos;
    logic             in_range;
    logic             at_tail;
    logic             at_end;
    logic             match;
    logic             need_emit;
    logic             advance;

    assign out_free  = !rvalid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire   = cmd.valid && cmd.ready;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - CNT_W'(1);
    assign step_cnt = CNT_W'(step_reg);
    assign step_inc = {1'b0, step_reg} + (IDX_W+1)'(1);
    assign step_pos = POS_W'(step_inc);
    assign in_range = (step_cnt < count_reg);
    assign at_tail  = (step_cnt == count_m1);
    assign at_end   = (step_reg == IDX_W'(DEPTH - 1));
    assign match    = (head == key_reg);

    always_comb
    begin
        need_emit = 1'b0;
        unique case (wcmd_reg)
            CMD_DUMP:     need_emit = in_range;
            CMD_SEARCH:   need_emit = !found_reg && in_range && (match || at_tail);
            CMD_POP_BACK: need_emit = at_tail;
            default:      need_emit = 1'b0;
        endcase
    end

    assign advance = !need_emit || out_free;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        wcmd_next   = wcmd_reg;
        key_next    = key_reg;
        found_next  = found_reg;
        rvalid_next = rvalid_reg && !res.ready;
        status_next = status_reg;
        rval_next   = rval_reg;
        pos_next    = pos_reg;
        last_next   = last_reg;
        ctl.op      = CELL_HOLD;
        ctl.operand = cmd.operand_value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    status_next = STAT_OK;
                    rval_next   = '0;
                    pos_next    = '0;
                    last_next   = 1'b1;
                    unique case (cmd.command)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            rvalid_next = 1'b1;
                            if (full)
                            begin
                                status_next = STAT_OVERFLOW;
                            end
                            else
                            begin
                                ctl.op     = (cmd.command == CMD_PUSH_FRONT) ?
                                             CELL_SHR : CELL_PUSH_BACK;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            rvalid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                ctl.op     = CELL_SHL;
                                rval_next  = head;
                                count_next = count_m1;
                            end
                        end
                        CMD_POP_BACK, CMD_DUMP, CMD_SEARCH:
                        begin
                            if (empty)
                            begin
                                rvalid_next = 1'b1;
                                status_next = (cmd.command == CMD_POP_BACK) ?
                                              STAT_UNDERFLOW : STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                                step_next  = '0;
                                wcmd_next  = cmd.command;
                                key_next   = cmd.operand_value;
                                found_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (advance)
                begin
                    ctl.op = CELL_SHL;
                    if (need_emit)
                    begin
                        rvalid_next = 1'b1;
                        status_next = STAT_OK;
                        rval_next   = head;
                        pos_next    = step_pos;
                        last_next   = 1'b1;
                        if (wcmd_reg == CMD_DUMP)
                        begin
                            last_next = at_tail;
                        end
                        else if (wcmd_reg == CMD_SEARCH)
                        begin
                            found_next = 1'b1;
                            if (!match)
                            begin
                                status_next = STAT_NOT_FOUND;
                                rval_next   = '0;
                                pos_next    = '0;
                            end
                        end
                        else
                        begin
                            pos_next = '0;
                        end
                    end
                    if (at_end)
                    begin
                        state_next = ST_IDLE;
                        step_next  = '0;
                        if (wcmd_reg == CMD_POP_BACK)
                        begin
                            count_next = count_m1;
                        end
                    end
                    else
                    begin
                        step_next = step_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            found_reg  <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            found_reg  <= found_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wcmd_reg   <= wcmd_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        rval_reg   <= rval_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
    end

    assign res.valid        = rvalid_reg;
    assign res.status       = status_reg;
    assign res.result_value = rval_reg;
    assign res.position     = pos_reg;
    assign res.last         = last_reg;
    assign fill_count       = count_reg;

    `BDQS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `BDQS_ASSERT_SAME(a_idle_step, state_reg == ST_IDLE, step_reg == '0, "walk step not cleared")
    `BDQS_ASSERT_NEXT(a_walk_count, state_reg == ST_WALK && !(advance && at_end),
                      $stable(count_reg), "entry count moved during walk")
    `BDQS_ASSERT_NEXT(a_walk_start, in_fire && !empty && (cmd.command == CMD_DUMP ||
                      cmd.command == CMD_SEARCH || cmd.command == CMD_POP_BACK),
                      state_reg == ST_WALK, "walk did not start")
    `BDQS_ASSERT_SAME(a_search_once, state_reg == ST_WALK && wcmd_reg == CMD_SEARCH &&
                      found_reg, !need_emit, "second search result")

endmodule

// ===== rtl/core/bounded_deque_with_search_top.sv =====
// Timing: push, pop front and any defined command on an empty list give a registered result
// in the cycle after the request; pop back, dump and search rotate the row through all DEPTH
// cells, a length set by the controller. Throughput: one request per cycle for other commands
// while each result is taken; none is accepted during a walk; a stalled result holds the walk.
// Reset: asynchronous, active low; clears entry count, sequencer and result valid.
// ----------------------------------------------------------------------------
// bounded_deque_with_search_top
// Deque of signed values held in a shifting row of cells, with dump and search.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_top #(
    parameter int DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    bdqs_cmd_if.sink   cmd,
    bdqs_res_if.source res
);
    import bdqs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    cell_ctrl_t              ctl;
    logic [CNT_W-1:0]        fill_count;
    logic signed [VAL_W-1:0] cell_value [DEPTH];

    bdqs_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .res        (res),
        .head       (cell_value[0]),
        .ctl        (ctl),
        .fill_count (fill_count)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bdqs_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .fill_count  (fill_count),
            .left_value  ((i == 0) ? ctl.operand : cell_value[(i + DEPTH - 1) % DEPTH]),
            .right_value (cell_value[(i + 1) % DEPTH]),
            .value       (cell_value[i])
        );
    end

endmodule
